### rtl/assert_macros.svh
// Assertion helper macros shared by the RTL modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### rtl/msp_enc_pkg.sv
// Shared types, constants and byte functions of the MSP RC frame encoder.
// No dependencies; used by the interfaces, the sequencer and the top level.
package msp_enc_pkg;

   localparam int unsigned CHAN_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VERSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER   = 2'd1;

   // protocol versions
   localparam logic [1:0] VER_V1 = 2'd1;
   localparam logic [1:0] VER_V2 = 2'd2;

   localparam logic [7:0] MSP_SYNC0     = 8'h24;
   localparam logic [7:0] MSP_SYNC_V1   = 8'h4d;
   localparam logic [7:0] MSP_SYNC_V2   = 8'h58;
   localparam logic [7:0] MSP_DIR_TO_FC = 8'h3c;
   localparam logic [7:0] MSP_CMD_RC    = 8'hc8;
   localparam logic [7:0] MSP_FLAG_V2   = 8'h00;
   localparam logic [7:0] CRC_POLY      = 8'hD5;
   localparam logic [7:0] CRC_TOPBIT    = 8'h80;

   // header positions
   localparam logic [2:0] HDR_CHK_POS  = 3'd3;
   localparam logic [2:0] HDR_LAST_V1  = 3'd4;
   localparam logic [2:0] HDR_LAST_V2  = 3'd7;

   typedef struct packed {
      logic [1:0] version;
      logic       order;
      logic       clear;
   } cfg_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOPBIT) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic v2, input logic [2:0] pos,
                                           input logic [7:0] size_lo,
                                           input logic [7:0] size_hi);
      logic [7:0] b;
      b = 8'h00;
      if (v2) begin
         case (pos)
            3'd0: b = MSP_SYNC0;
            3'd1: b = MSP_SYNC_V2;
            3'd2: b = MSP_DIR_TO_FC;
            3'd3: b = MSP_FLAG_V2;
            3'd4: b = MSP_CMD_RC;
            3'd5: b = 8'h00;
            3'd6: b = size_lo;
            default: b = size_hi;
         endcase
      end else begin
         case (pos)
            3'd0: b = MSP_SYNC0;
            3'd1: b = MSP_SYNC_V1;
            3'd2: b = MSP_DIR_TO_FC;
            3'd3: b = size_lo;
            default: b = MSP_CMD_RC;
         endcase
      end
      return b;
   endfunction

endpackage

### rtl/msp_enc_if.sv
// Valid/ready channel interfaces of the MSP RC frame encoder.
// Depends on msp_enc_pkg for payload widths.
interface msp_enc_req_if;
   logic                              valid;
   logic                              ready;
   logic [msp_enc_pkg::CHAN_W-1:0]    channel_value;
   modport source (output valid, output channel_value, input ready);
   modport sink   (input valid, input channel_value, output ready);
endinterface

interface msp_enc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [msp_enc_pkg::BYTE_W-1:0]    out_byte;
   logic                              run_last;
   logic                              frame_end;
   modport source (output valid, output out_byte, output run_last, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_end,
                   output ready);
endinterface

interface msp_enc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [msp_enc_pkg::CSR_IDX_W-1:0]    index;
   logic [msp_enc_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/msp_rc_frame_encoder_top.sv
// Top level of the MSP set-raw-RC frame encoder: register port and byte sequencer.
// Depends on msp_enc_pkg, msp_enc_if and msp_enc_seq.
//
// Usage:
//   req_chan carries one RC channel value per request, in frame order (roll, pitch,
//   yaw, throttle, aux...). rsp_chan returns the frame one byte per transfer, with
//   run_last on the last byte caused by a request and frame_end on the checksum byte.
//   csr_chan writes register 0 (version: 1 = MSP v1/XOR, 2 = MSP v2/CRC-8) and
//   register 1 (0 = channel high byte first, 1 = low byte first); any write to
//   either register restarts the frame. Write registers only while the block is idle.
// Timing:
//   The first byte of a request passes the input register, then the byte register.
//   The sequencer emits one byte per cycle unless rsp_chan stalls: two bytes for a
//   middle channel, plus 5 (v1) or 8 (v2) header bytes on the first, one checksum
//   byte on the last. The next request is taken as the current emits its last byte.
// Reset puts the block at version 1, high byte first, at the start of a frame;
// both ready outputs stay low while reset is high.
// A stalled receiver holds the byte register; one request waits in the input
// register, then req_chan.ready falls. Requests under an unknown version are dropped.
module msp_rc_frame_encoder_top #(
   parameter int unsigned CHANNELS = 14
) (
   input  logic           clock,
   input  logic           reset,
   msp_enc_req_if.sink    req_chan,
   msp_enc_rsp_if.source  rsp_chan,
   msp_enc_csr_if.sink    csr_chan
);

   logic [1:0]           ver_ff, ver_in;
   logic                 order_ff, order_in;
   logic                 clear;
   logic                 csr_acc;
   msp_enc_pkg::cfg_type cfg;

   assign csr_chan.ready = !reset;
   assign csr_acc        = csr_chan.valid && csr_chan.ready;

   always_comb begin
      ver_in   = ver_ff;
      order_in = order_ff;
      clear    = 1'b0;
      if (csr_acc) begin
         unique case (csr_chan.index)
            msp_enc_pkg::REG_VERSION: begin
               ver_in = csr_chan.data[1:0];
               clear  = 1'b1;
            end
            msp_enc_pkg::REG_ORDER: begin
               order_in = csr_chan.data[0];
               clear    = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff   <= msp_enc_pkg::VER_V1;
         order_ff <= 1'b0;
      end else begin
         ver_ff   <= ver_in;
         order_ff <= order_in;
      end
   end

   assign cfg.version = ver_ff;
   assign cfg.order   = order_ff;
   assign cfg.clear   = clear;

   msp_enc_seq #(
      .CHANNELS (CHANNELS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/msp_enc_seq.sv
// Byte sequencer: request register, frame position, running checksum, byte register.
// Depends on msp_enc_pkg, msp_enc_if and assert_macros.svh.
`include "assert_macros.svh"

module msp_enc_seq #(
   parameter int unsigned CHANNELS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  msp_enc_pkg::cfg_type cfg,
   msp_enc_req_if.sink          req_chan,
   msp_enc_rsp_if.source        rsp_chan
);

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned SIZE  = 2 * CHANNELS;
   localparam logic [7:0] SIZE_LO = 8'(SIZE);
   localparam logic [7:0] SIZE_HI = 8'(SIZE >> 8);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   localparam logic [1:0] PH_HDR = 2'd0;
   localparam logic [1:0] PH_CH0 = 2'd1;
   localparam logic [1:0] PH_CH1 = 2'd2;
   localparam logic [1:0] PH_CHK = 2'd3;

   logic                                in_vld_ff, in_vld_in;
   logic [msp_enc_pkg::CHAN_W-1:0]      in_val_ff;
   logic [1:0]                          phase_ff, phase_in;
   logic [2:0]                          hpos_ff, hpos_in;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic [7:0]                          chk_ff, chk_in;
   logic                                out_vld_ff, out_vld_in;
   logic [7:0]                          out_byte_ff;
   logic                                out_last_ff, out_end_ff;

   logic       ver_ok, v2;
   logic [7:0] hi_byte, lo_byte, cur_byte;
   logic       cur_chk, cur_done, cur_end;
   logic [1:0] ph_next;
   logic [2:0] hpos_next;
   logic       adv, drop, finish, req_acc;

   assign ver_ok  = (cfg.version == msp_enc_pkg::VER_V1) ||
                    (cfg.version == msp_enc_pkg::VER_V2);
   assign v2      = (cfg.version == msp_enc_pkg::VER_V2);
   assign hi_byte = in_val_ff[15:8];
   assign lo_byte = in_val_ff[7:0];

   always_comb begin
      cur_byte  = 8'h00;
      cur_chk   = 1'b0;
      cur_done  = 1'b0;
      cur_end   = 1'b0;
      ph_next   = phase_ff;
      hpos_next = hpos_ff;
      unique case (phase_ff)
         PH_HDR: begin
            cur_byte = msp_enc_pkg::hdr_byte(v2, hpos_ff, SIZE_LO, SIZE_HI);
            cur_chk  = (hpos_ff >= msp_enc_pkg::HDR_CHK_POS);
            if ((v2 && hpos_ff == msp_enc_pkg::HDR_LAST_V2) ||
                (!v2 && hpos_ff == msp_enc_pkg::HDR_LAST_V1)) begin
               ph_next = PH_CH0;
            end else begin
               hpos_next = hpos_ff + 3'd1;
            end
         end
         PH_CH0: begin
            cur_byte = cfg.order ? lo_byte : hi_byte;
            cur_chk  = 1'b1;
            ph_next  = PH_CH1;
         end
         PH_CH1: begin
            cur_byte = cfg.order ? hi_byte : lo_byte;
            cur_chk  = 1'b1;
            if (idx_ff == LAST_IDX) begin
               ph_next = PH_CHK;
            end else begin
               cur_done = 1'b1;
            end
         end
         PH_CHK: begin
            cur_byte = chk_ff;
            cur_done = 1'b1;
            cur_end  = 1'b1;
         end
         default: ;
      endcase
   end

   // an unknown version consumes the request without output
   assign adv    = in_vld_ff && ver_ok && (!out_vld_ff || rsp_chan.ready);
   assign drop   = in_vld_ff && !ver_ok;
   assign finish = drop || (adv && cur_done);

   assign req_chan.ready = !reset && (!in_vld_ff || finish);
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_comb begin
      idx_in = idx_ff;
      chk_in = chk_ff;
      if (cfg.clear) begin
         idx_in = '0;
         chk_in = 8'h00;
      end else if (adv) begin
         if (phase_ff == PH_CHK) begin
            idx_in = '0;
            chk_in = 8'h00;
         end else begin
            if (cur_chk) begin
               chk_in = v2 ? msp_enc_pkg::crc8_update(chk_ff, cur_byte) : (chk_ff ^ cur_byte);
            end
            if (phase_ff == PH_CH1 && idx_ff != LAST_IDX) begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      if (finish) begin
         in_vld_in = 1'b0;
      end
      if (adv) begin
         phase_in = ph_next;
         hpos_in  = hpos_next;
      end
      // a new request opens a frame when the position is back at zero
      if (req_acc) begin
         in_vld_in = 1'b1;
         phase_in  = (idx_in == '0) ? PH_HDR : PH_CH0;
         hpos_in   = 3'd0;
      end
      out_vld_in = out_vld_ff;
      if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
      if (adv) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         phase_ff   <= PH_HDR;
         hpos_ff    <= 3'd0;
         idx_ff     <= '0;
         chk_ff     <= 8'h00;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         phase_ff   <= phase_in;
         hpos_ff    <= hpos_in;
         idx_ff     <= idx_in;
         chk_ff     <= chk_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_val_ff <= req_chan.channel_value;
      end
      if (adv) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= cur_done;
         out_end_ff  <= cur_end;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.run_last  = out_last_ff;
   assign rsp_chan.frame_end = out_end_ff;

   `ASSERT_PROP(a_end_is_last, clock, reset, (out_vld_ff && out_end_ff) |-> out_last_ff)
   `ASSERT_PROP(a_hdr_at_start, clock, reset, (in_vld_ff && phase_ff == PH_HDR) |-> (idx_ff == '0))
   `ASSERT_PROP(a_idle_chk_clear, clock, reset, (!in_vld_ff && idx_ff == '0) |-> (chk_ff == 8'h00))
   `ASSERT_NEVER(a_idx_range, clock, reset, idx_ff > LAST_IDX)

endmodule
